// ===== src/smm_pkg.sv =====
// shared types, sizes and helpers for the square matrix multiply core
package smm_pkg;

  // built-in maximum matrix dimension and element width
  localparam int MAX_DIM   = 16;
  localparam int ELEM_BITS = 16;

  // fixed field widths of the ports
  localparam int OP_BITS    = 2;
  localparam int IDX_FIELD  = 4;
  localparam int SIZE_BITS  = 5;
  localparam int SUM_BITS   = 36;

  // derived widths
  localparam int IDX_BITS   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_BITS  = $clog2(MAX_DIM * MAX_DIM);
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int CNT_BITS   = $clog2(MAX_DIM + 1);
  localparam int PROD_BITS  = 2 * ELEM_BITS;

  // size register value after reset
  localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(16);

  // opcodes
  typedef enum logic [OP_BITS-1:0] {
    OP_WRITE_P = 2'd0,
    OP_WRITE_Q = 2'd1,
    OP_READ_R  = 2'd2,
    OP_NONE    = 2'd3
  } smm_op_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } smm_state_t;

  // controls from sequencer to multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic issue;
    logic last;
  } smm_mac_ctl_t;

  // dimension in use: zero acts as one, large values saturate
  function automatic logic [CNT_BITS-1:0] dim_of(input logic [SIZE_BITS-1:0] size);
    logic [CNT_BITS-1:0] d;
    if (size == '0) begin
      d = CNT_BITS'(1);
    end else if (int'(size) > MAX_DIM) begin
      d = CNT_BITS'(MAX_DIM);
    end else begin
      d = CNT_BITS'(size);
    end
    return d;
  endfunction

  // index within the built-in maximum
  function automatic logic idx_ok(input logic [IDX_FIELD-1:0] idx);
    return int'(idx) < MAX_DIM;
  endfunction

endpackage

// ===== src/smm_ram.sv =====
// generic single-write, single-read ram with registered read data
module smm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/smm_mac.sv =====
// shared multiply-accumulate unit: product register then accumulator
module smm_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  smm_pkg::smm_mac_ctl_t               ctl,
  input  logic signed [smm_pkg::ELEM_BITS-1:0] a,
  input  logic signed [smm_pkg::ELEM_BITS-1:0] b,
  output logic signed [smm_pkg::SUM_BITS-1:0]  sum,
  output logic                                done
);

  logic                                      v1_r, l1_r;
  logic                                      v2_r, l2_r;
  logic signed [smm_pkg::PROD_BITS-1:0]      prod_r;
  logic signed [smm_pkg::SUM_BITS-1:0]       acc_r;
  logic                                      done_r;

  // align issue flags with registered ram data, then with the product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      l1_r   <= 1'b0;
      v2_r   <= 1'b0;
      l2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= ctl.issue;
      l1_r   <= ctl.issue & ctl.last;
      v2_r   <= v1_r;
      l2_r   <= l1_r;
      done_r <= v2_r & l2_r;
    end
  end

  // product register
  always_ff @(posedge clk) begin
    if (v1_r) begin
      prod_r <= a * b;
    end
  end

  // accumulator, cleared when a request starts
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + smm_pkg::SUM_BITS'(prod_r);
    end
  end

  assign sum  = acc_r;
  assign done = done_r;

endmodule

// ===== src/smm_ctrl.sv =====
// sequencer: handshakes, size register, store addressing and result register
module smm_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [smm_pkg::OP_BITS-1:0]          in_opcode,
  input  logic [smm_pkg::IDX_FIELD-1:0]        in_row,
  input  logic [smm_pkg::IDX_FIELD-1:0]        in_col,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [smm_pkg::SUM_BITS-1:0]  out_product_sum,
  // configuration
  input  logic                                 cfg_wr_en,
  input  logic [smm_pkg::SIZE_BITS-1:0]        cfg_wr_data,
  // store ports
  output logic                                 p_we,
  output logic                                 q_we,
  output logic [smm_pkg::ADDR_BITS-1:0]        p_waddr,
  output logic [smm_pkg::ADDR_BITS-1:0]        q_waddr,
  output logic                                 rd_en,
  output logic [smm_pkg::ADDR_BITS-1:0]        p_raddr,
  output logic [smm_pkg::ADDR_BITS-1:0]        q_raddr,
  // multiply-accumulate unit
  output smm_pkg::smm_mac_ctl_t                mac_ctl,
  input  logic signed [smm_pkg::SUM_BITS-1:0]  mac_sum,
  input  logic                                 mac_done
);

  smm_pkg::smm_state_t                 state_r, state_nxt;
  logic [smm_pkg::SIZE_BITS-1:0]       size_r;
  logic [smm_pkg::CNT_BITS-1:0]        k_r;
  logic [smm_pkg::CNT_BITS-1:0]        n_r;
  logic [smm_pkg::IDX_BITS-1:0]        row_r;
  logic [smm_pkg::IDX_BITS-1:0]        col_r;
  logic                                out_valid_r;
  logic signed [smm_pkg::SUM_BITS-1:0] out_sum_r;

  logic                                accept;
  logic                                in_range;
  logic                                is_read;
  logic                                last_k;
  logic                                out_free;
  logic [smm_pkg::IDX_BITS-1:0]        k_idx;
  logic [smm_pkg::IDX_BITS-1:0]        in_row_idx;
  logic [smm_pkg::IDX_BITS-1:0]        in_col_idx;

  assign accept     = in_valid & in_ready;
  assign in_range   = smm_pkg::idx_ok(in_row) & smm_pkg::idx_ok(in_col);
  assign is_read    = (smm_pkg::smm_op_t'(in_opcode) == smm_pkg::OP_READ_R);
  assign last_k     = (k_r == n_r - smm_pkg::CNT_BITS'(1));
  assign out_free   = ~out_valid_r | out_ready;
  assign k_idx      = k_r[smm_pkg::IDX_BITS-1:0];
  assign in_row_idx = smm_pkg::IDX_BITS'(in_row);
  assign in_col_idx = smm_pkg::IDX_BITS'(in_col);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smm_pkg::ST_IDLE: begin
        if (accept && is_read) begin
          state_nxt = in_range ? smm_pkg::ST_RUN : smm_pkg::ST_FINISH;
        end
      end
      smm_pkg::ST_RUN: begin
        if (last_k) begin
          state_nxt = smm_pkg::ST_DRAIN;
        end
      end
      smm_pkg::ST_DRAIN: begin
        if (mac_done) begin
          state_nxt = smm_pkg::ST_FINISH;
        end
      end
      smm_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = smm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = smm_pkg::ST_IDLE;
    endcase
  end

  // outputs per state; ready is always high in idle, so valid alone means a beat
  always_comb begin
    in_ready      = 1'b0;
    rd_en         = 1'b0;
    mac_ctl.clear = 1'b0;
    mac_ctl.issue = 1'b0;
    mac_ctl.last  = 1'b0;
    p_we          = 1'b0;
    q_we          = 1'b0;
    case (state_r)
      smm_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        mac_ctl.clear = in_valid & is_read;
        p_we          = in_valid & in_range &
                        (smm_pkg::smm_op_t'(in_opcode) == smm_pkg::OP_WRITE_P);
        q_we          = in_valid & in_range &
                        (smm_pkg::smm_op_t'(in_opcode) == smm_pkg::OP_WRITE_Q);
      end
      smm_pkg::ST_RUN: begin
        rd_en         = 1'b1;
        mac_ctl.issue = 1'b1;
        mac_ctl.last  = last_k;
      end
      smm_pkg::ST_DRAIN: begin
      end
      smm_pkg::ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // store addresses: q is kept transposed
  assign p_waddr = smm_pkg::ADDR_BITS'(in_row_idx) * smm_pkg::ADDR_BITS'(smm_pkg::MAX_DIM)
                 + smm_pkg::ADDR_BITS'(in_col_idx);
  assign q_waddr = smm_pkg::ADDR_BITS'(in_col_idx) * smm_pkg::ADDR_BITS'(smm_pkg::MAX_DIM)
                 + smm_pkg::ADDR_BITS'(in_row_idx);
  assign p_raddr = smm_pkg::ADDR_BITS'(row_r) * smm_pkg::ADDR_BITS'(smm_pkg::MAX_DIM)
                 + smm_pkg::ADDR_BITS'(k_idx);
  assign q_raddr = smm_pkg::ADDR_BITS'(col_r) * smm_pkg::ADDR_BITS'(smm_pkg::MAX_DIM)
                 + smm_pkg::ADDR_BITS'(k_idx);

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smm_pkg::ST_IDLE;
      size_r      <= smm_pkg::SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end
      if (state_r == smm_pkg::ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request registers and element counter
  always_ff @(posedge clk) begin
    if (accept && is_read) begin
      row_r <= in_row_idx;
      col_r <= in_col_idx;
      n_r   <= smm_pkg::dim_of(size_r);
      k_r   <= '0;
    end else if (state_r == smm_pkg::ST_RUN) begin
      k_r <= k_r + smm_pkg::CNT_BITS'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == smm_pkg::ST_FINISH && out_free) begin
      out_sum_r <= mac_sum;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_product_sum = out_sum_r;

endmodule

// ===== src/square_matrix_multiply_core.sv =====
// top level of the square matrix multiply core
//
//   channel   direction  handshake              payload
//   in_       input      in_valid / in_ready    in_opcode, in_row, in_col, in_element_value
//   out_      output     out_valid / out_ready  out_product_sum
//   cfg_      input      cfg_wr_en              cfg_wr_data (size in use)
//
// a write of p or q is stored as it is taken; a read of r walks the n stored
// pairs through the one multiply-accumulate unit, behind the registered reads
// of the two element stores.
// reset is synchronous, active low; the element stores are not cleared.
// in_ready is low while a read runs; a result waits in the output register
// and a new write is taken meanwhile.
module square_matrix_multiply_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [smm_pkg::OP_BITS-1:0]          in_opcode,
  input  logic [smm_pkg::IDX_FIELD-1:0]        in_row,
  input  logic [smm_pkg::IDX_FIELD-1:0]        in_col,
  input  logic signed [smm_pkg::ELEM_BITS-1:0] in_element_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [smm_pkg::SUM_BITS-1:0]  out_product_sum,
  input  logic                                 cfg_wr_en,
  input  logic [smm_pkg::SIZE_BITS-1:0]        cfg_wr_data
);

  logic                                  p_we, q_we, rd_en;
  logic [smm_pkg::ADDR_BITS-1:0]         p_waddr, q_waddr, p_raddr, q_raddr;
  logic [smm_pkg::ELEM_BITS-1:0]         p_rdata, q_rdata;
  smm_pkg::smm_mac_ctl_t                 mac_ctl;
  logic signed [smm_pkg::SUM_BITS-1:0]   mac_sum;
  logic                                  mac_done;

  // sequencer
  smm_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_row          (in_row),
    .in_col          (in_col),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_product_sum (out_product_sum),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .p_we            (p_we),
    .q_we            (q_we),
    .p_waddr         (p_waddr),
    .q_waddr         (q_waddr),
    .rd_en           (rd_en),
    .p_raddr         (p_raddr),
    .q_raddr         (q_raddr),
    .mac_ctl         (mac_ctl),
    .mac_sum         (mac_sum),
    .mac_done        (mac_done)
  );

  // left matrix store
  smm_ram #(
    .WIDTH (smm_pkg::ELEM_BITS),
    .DEPTH (smm_pkg::DEPTH)
  ) u_p_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (in_element_value),
    .re    (rd_en),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  // right matrix store, transposed
  smm_ram #(
    .WIDTH (smm_pkg::ELEM_BITS),
    .DEPTH (smm_pkg::DEPTH)
  ) u_q_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (in_element_value),
    .re    (rd_en),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // shared multiply-accumulate unit
  smm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a     (signed'(p_rdata)),
    .b     (signed'(q_rdata)),
    .sum   (mac_sum),
    .done  (mac_done)
  );

endmodule
